>>> src/stack_frame_allocator_defines.svh
// Assertion macros used by the page frame allocator controller.
`ifndef STACK_FRAME_ALLOCATOR_DEFINES_SVH
`define STACK_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sfa_pkg.sv
// Types and constants of the page frame allocator.
package sfa_pkg;

    localparam int PAGE_NUMBER_BITS    = 44;
    localparam int STACK_DEPTH_DEFAULT = 64;

    typedef logic [PAGE_NUMBER_BITS-1:0] page_t;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic
    {
        CFG_RANGE_START = 1'b0,
        CFG_RANGE_END   = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0]
    {
        ST_FROM_STACK = 3'd0,
        ST_FROM_RANGE = 3'd1,
        ST_EXHAUSTED  = 3'd2,
        ST_FREED      = 3'd3,
        ST_NOT_ALLOC  = 3'd4,
        ST_DUP_FULL   = 3'd5
    } status_t;

    typedef struct packed
    {
        logic  operation;
        page_t page_number;
    } req_word_t;

    typedef struct packed
    {
        page_t   granted_page;
        status_t status;
    } rsp_word_t;

    typedef struct packed
    {
        cfg_reg_t index;
        page_t    value;
    } cfg_word_t;

    // Controller to datapath
    typedef struct packed
    {
        logic latch;
        logic rd_pop;
        logic rd_scan;
        logic commit;
    } sfa_cmd_t;

    // Datapath to controller
    typedef struct packed
    {
        logic op_free;
        logic count_zero;
        logic not_alloc;
        logic scan_last;
    } sfa_sts_t;

endpackage

>>> src/sfa_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface sfa_chan_if #(parameter type payload_t = logic) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> src/sfa_ctrl.sv
// Sequencing state machine of the page frame allocator.
`include "stack_frame_allocator_defines.svh"

module sfa_ctrl
    import sfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  sfa_sts_t sts,
    output sfa_cmd_t cmd
);

    typedef enum logic [3:0]
    {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.latch   = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!sts.op_free)
                begin
                    // fetch the top entry, only when the stack is not empty
                    cmd.rd_pop = !sts.count_zero;
                    state_next = S_FINISH;
                end
                else if (sts.not_alloc || sts.count_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    `SFA_ASSERT_NEXT(a_accept_decides, accept, state_reg == S_DECIDE, "accept did not advance")
    `SFA_ASSERT_NOW(a_no_overwrite, cmd.commit, !rsp_valid_reg || rsp_ready, "result overwritten")
    `SFA_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid_reg, "committed word not presented")
    `SFA_ASSERT_NEXT(a_scan_runs, state_reg == S_SCAN && !sts.scan_last, state_reg == S_SCAN,
        "scan ended early")

endmodule

>>> src/sfa_datapath.sv
// Pointer, recycle stack memory, duplicate compare and result register.
module sfa_datapath
    import sfa_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  cfg_word_t cfg_word,
    input  req_word_t req_word,
    input  sfa_cmd_t  cmd,
    output sfa_sts_t  sts,
    output rsp_word_t rsp_word
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    page_t   mem [STACK_DEPTH];

    page_t   next_free_reg;
    page_t   next_free_next;
    page_t   range_end_reg;
    page_t   range_end_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_dec;
    logic [AW-1:0] scan_idx_reg;
    logic [AW-1:0] scan_idx_next;
    logic    hit_reg;
    logic    hit_next;
    logic    cmp_valid_reg;
    logic    cmp_valid_next;
    logic    op_reg;
    page_t   page_reg;
    page_t   rd_data_reg;
    logic    rd_en;
    logic [AW-1:0] rd_addr;
    logic    push;
    logic    dup;
    logic    stack_full;
    logic    exhausted;
    page_t   granted_reg;
    page_t   granted_next;
    status_t status_reg;
    status_t status_next;

    assign count_dec  = count_reg - CW'(1);
    assign stack_full = (count_reg == CW'(STACK_DEPTH));
    assign exhausted  = (next_free_reg >= range_end_reg);
    assign dup        = hit_reg || (cmp_valid_reg && (rd_data_reg == page_reg));

    assign rd_en   = cmd.rd_pop || cmd.rd_scan;
    assign rd_addr = cmd.rd_scan ? scan_idx_reg : count_dec[AW-1:0];

    assign sts.op_free    = (op_reg == OP_FREE);
    assign sts.count_zero = (count_reg == '0);
    assign sts.not_alloc  = (page_reg >= next_free_reg);
    assign sts.scan_last  = (CW'(scan_idx_reg) == count_dec);

    assign rsp_word.granted_page = granted_reg;
    assign rsp_word.status       = status_reg;

    always_comb
    begin
        next_free_next = next_free_reg;
        range_end_next = range_end_reg;
        count_next     = count_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        push           = 1'b0;

        if (cmd.commit)
        begin
            granted_next = '0;
            if (op_reg == OP_ALLOC)
            begin
                if (count_reg != '0)
                begin
                    count_next   = count_dec;
                    granted_next = rd_data_reg;
                    status_next  = ST_FROM_STACK;
                end
                else if (exhausted)
                begin
                    status_next = ST_EXHAUSTED;
                end
                else
                begin
                    granted_next   = next_free_reg;
                    next_free_next = next_free_reg + page_t'(1);
                    status_next    = ST_FROM_RANGE;
                end
            end
            else
            begin
                if (page_reg >= next_free_reg)
                begin
                    status_next = ST_NOT_ALLOC;
                end
                else if (dup || stack_full)
                begin
                    status_next = ST_DUP_FULL;
                end
                else
                begin
                    push        = 1'b1;
                    count_next  = count_reg + CW'(1);
                    status_next = ST_FREED;
                end
            end
        end

        if (cfg_we)
        begin
            case (cfg_word.index)
                CFG_RANGE_START:
                begin
                    // reload the pointer and drop every stacked page
                    next_free_next = cfg_word.value;
                    count_next     = '0;
                end
                CFG_RANGE_END:
                begin
                    range_end_next = cfg_word.value;
                end
                default:
                begin
                    range_end_next = range_end_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        scan_idx_next  = scan_idx_reg;
        hit_next       = hit_reg || (cmp_valid_reg && (rd_data_reg == page_reg));
        cmp_valid_next = cmd.rd_scan;
        if (cmd.latch)
        begin
            scan_idx_next  = '0;
            hit_next       = 1'b0;
            cmp_valid_next = 1'b0;
        end
        else if (cmd.rd_scan)
        begin
            scan_idx_next = scan_idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg <= '0;
            range_end_reg <= '0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            hit_reg       <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            next_free_reg <= next_free_next;
            range_end_reg <= range_end_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            hit_reg       <= hit_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= req_word.operation;
            page_reg <= req_word.page_number;
        end
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[count_reg[AW-1:0]] <= page_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

>>> src/stack_frame_allocator.sv
// Allocate presents the top of the recycle stack, read from its memory, or issues the next
// page of [range_start, range_end), or returns page 0 with the exhausted status. Free presents
// its result after a scan of all stacked pages for a duplicate; it skips the scan when the
// page was never issued or the stack is empty. The duplicate check reads one stack entry a
// cycle through the single read port of the stack memory. The next request can be taken in
// the same cycle as the result appears. One request is in flight at a time; a new request is
// taken while the previous result still waits in the output register. Writing range_start
// reloads the pointer and empties the stack; write registers only while idle.
module stack_frame_allocator
    import sfa_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    sfa_chan_if.sink   cfg,
    sfa_chan_if.sink   req,
    sfa_chan_if.source rsp
);

    sfa_cmd_t  cmd;
    sfa_sts_t  sts;
    cfg_word_t cfg_word;
    req_word_t req_word;
    rsp_word_t rsp_word;

    assign cfg.ready = 1'b1;
    assign cfg_word  = cfg.data;
    assign req_word  = req.data;
    assign rsp.data  = rsp_word;

    sfa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sfa_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg.valid),
        .cfg_word (cfg_word),
        .req_word (req_word),
        .cmd      (cmd),
        .sts      (sts),
        .rsp_word (rsp_word)
    );

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the stack page frame allocator: directed and random requests.
`timescale 1ns / 1ps

module testbench;
    import sfa_pkg::*;

    localparam int    STACK_SLOTS     = STACK_DEPTH_DEFAULT;
    localparam int    FILL_PAGES      = STACK_SLOTS + 4;
    localparam int    ITEMS_PER_PHASE = 30;
    localparam int    STALL_LIMIT     = 3000;
    localparam int    LONG_HOLD       = 300;
    localparam page_t PAGE_MAX        = {PAGE_NUMBER_BITS{1'b1}};

    // Predicts each grant or free verdict and holds the ones still owed by the block.
    class frame_ledger;
        page_t     range_start_q;
        page_t     range_end_q;
        page_t     next_free_q;
        page_t     stacked_q [STACK_SLOTS];
        int        stacked_count;
        rsp_word_t pending [$];
        int        mismatches;
        int        requests_noted;
        int        config_writes;
        int        status_seen [6];

        function new();
            range_start_q = '0;
            range_end_q   = '0;
            next_free_q   = '0;
        endfunction

        function void apply_config(cfg_reg_t idx, page_t value);
            config_writes++;
            if (idx == CFG_RANGE_START)
            begin
                range_start_q = value;
                next_free_q   = value;
                stacked_count = 0;
            end
            else
            begin
                range_end_q = value;
            end
        endfunction

        function bit is_stacked(page_t page);
            for (int k = 0; k < stacked_count; k++)
            begin
                if (stacked_q[k] == page)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(req_word_t word);
            rsp_word_t grant;
            grant.granted_page = '0;
            if (word.operation == OP_ALLOC)
            begin
                if (stacked_count > 0)
                begin
                    stacked_count--;
                    grant.granted_page = stacked_q[stacked_count];
                    grant.status       = ST_FROM_STACK;
                end
                else if (next_free_q >= range_end_q)
                begin
                    grant.status = ST_EXHAUSTED;
                end
                else
                begin
                    grant.granted_page = next_free_q;
                    next_free_q        = next_free_q + 1'b1;
                    grant.status       = ST_FROM_RANGE;
                end
            end
            else if (word.page_number >= next_free_q)
            begin
                grant.status = ST_NOT_ALLOC;
            end
            else if (is_stacked(word.page_number) || stacked_count >= STACK_SLOTS)
            begin
                grant.status = ST_DUP_FULL;
            end
            else
            begin
                stacked_q[stacked_count] = word.page_number;
                stacked_count++;
                grant.status = ST_FREED;
            end
            pending.push_back(grant);
            requests_noted++;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("%0t MISMATCH: %s", $realtime, msg);
        endtask

        task check_grant(rsp_word_t got);
            rsp_word_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("response page %h status %0d with nothing pending",
                                 got.granted_page, got.status));
                return;
            end
            want = pending.pop_front();
            status_seen[int'(want.status)]++;
            if (got.granted_page !== want.granted_page)
                report($sformatf("granted_page %h, want %h (%s)",
                                 got.granted_page, want.granted_page, want.status.name()));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %s", got.status, want.status.name()));
        endtask
    endclass

    logic clk;
    logic rst_n;

    sfa_chan_if #(.payload_t(cfg_word_t)) cfg_ch ();
    sfa_chan_if #(.payload_t(req_word_t)) req_ch ();
    sfa_chan_if #(.payload_t(rsp_word_t)) rsp_ch ();

    stack_frame_allocator dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    frame_ledger ledger = new();
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    bit          hold_request       = 1'b0;
    int          stuck_cycles       = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            ledger.check_grant(rsp_ch.data);
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("stack_frame_allocator verification failed");
            $finish;
        end
    end

    // Write range_end, and range_start first when asked; hold valid across both words.
    task automatic load_range(bit with_start, page_t first_page, page_t end_page);
        cfg_word_t word;
        if (with_start)
        begin
            word.index = CFG_RANGE_START;
            word.value = first_page;
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= word;
            do @(posedge clk); while (!cfg_ch.ready);
            ledger.apply_config(CFG_RANGE_START, first_page);
        end
        word.index = CFG_RANGE_END;
        word.value = end_page;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= word;
        do @(posedge clk); while (!cfg_ch.ready);
        ledger.apply_config(CFG_RANGE_END, end_page);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_request(op_t op, page_t page);
        req_word_t word;
        int        gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(1, 8);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word.operation   = op;
        word.page_number = page;
        req_ch.valid <= 1'b1;
        req_ch.data  <= word;
        do @(posedge clk); while (!req_ch.ready);
        ledger.note_request(word);
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (ledger.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly frees of issued pages and allocations; some duplicates and unissued pages.
    task automatic offer_random_request();
        int              pick;
        longint unsigned span;
        page_t           page;
        op_t             op;
        pick = $urandom_range(99);
        page = page_t'({$urandom, $urandom});
        op   = OP_FREE;
        span = longint'(ledger.next_free_q - ledger.range_start_q);
        if (pick < 45)
            op = OP_ALLOC;
        else if (pick < 75 && span > 0)
            page = ledger.range_start_q + page_t'({$urandom, $urandom} % span);
        else if (pick < 85 && ledger.stacked_count > 0)
            page = ledger.stacked_q[$urandom_range(0, ledger.stacked_count - 1)];
        else if (pick < 93)
            page = ledger.next_free_q + page_t'($urandom_range(0, 3));
        send_request(op, page);
    endtask

    // Issue more pages than the stack holds, free them all in random order, then pop some.
    task automatic fill_recycle_stack(page_t first_page);
        page_t issued [$];
        page_t swap;
        int    j;
        load_range(1'b1, first_page, first_page + page_t'(FILL_PAGES));
        for (int k = 0; k < FILL_PAGES; k++)
        begin
            issued.push_back(first_page + page_t'(k));
            send_request(OP_ALLOC, page_t'({$urandom, $urandom}));
        end
        for (int k = FILL_PAGES - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            swap = issued[k];
            issued[k] = issued[j];
            issued[j] = swap;
        end
        foreach (issued[k])
            send_request(OP_FREE, issued[k]);
        send_request(OP_FREE, issued[0]);
        repeat (4) send_request(OP_ALLOC, '0);
    endtask

    initial
    begin
        page_t base;
        int    span;
        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty range straight out of reset: exhausted, and nothing can be freed.
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, '0);
        send_request(OP_FREE, PAGE_MAX);
        wait_idle();

        load_range(1'b1, '0, page_t'(3));
        repeat (4) send_request(OP_ALLOC, PAGE_MAX);
        send_request(OP_FREE, page_t'(1));
        send_request(OP_FREE, page_t'(1));   // duplicate of the top entry
        send_request(OP_FREE, page_t'(0));
        send_request(OP_FREE, page_t'(1));   // duplicate below the top
        send_request(OP_FREE, page_t'(3));   // never issued
        send_request(OP_FREE, page_t'(2));
        repeat (4) send_request(OP_ALLOC, '0);
        wait_idle();

        // Top of the page space: pointer runs up to all ones.
        load_range(1'b1, PAGE_MAX - 3, PAGE_MAX);
        repeat (4) send_request(OP_ALLOC, '0);
        send_request(OP_FREE, PAGE_MAX - 1);
        send_request(OP_FREE, PAGE_MAX);
        send_request(OP_ALLOC, '0);
        wait_idle();

        // End bound moved below the pointer.
        load_range(1'b0, '0, page_t'(5));
        send_request(OP_ALLOC, '0);

        for (int phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            case (phase % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 70;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 70;
                end
                default:
                begin
                    sender_idle_pct    = 10;
                    receiver_stall_pct = 10;
                end
            endcase
            base = page_t'({$urandom, $urandom});
            span = (phase == 5) ? FILL_PAGES : $urandom_range(0, 40);
            if (base > PAGE_MAX - page_t'(span))
                base = PAGE_MAX - page_t'(span);
            if (phase == 5)
                fill_recycle_stack(base);
            else if (phase % 3 == 2)
                load_range(1'b0, '0,
                           ledger.next_free_q + page_t'($urandom_range(0, 6)) - page_t'(3));
            else
                load_range(1'b1, base, base + page_t'(span));
            if (phase == 0)
                hold_request = 1'b1;
            repeat (ITEMS_PER_PHASE) offer_random_request();
        end

        wait_idle();
        repeat (20) @(posedge clk);

        $display("Ran %0d requests under %0d register writes, across idle, stall and hold-off phases.",
                 ledger.requests_noted, ledger.config_writes);
        $display("Seen: %0d stack, %0d range, %0d exhausted, %0d freed, %0d unissued, %0d dup/full.",
                 ledger.status_seen[int'(ST_FROM_STACK)], ledger.status_seen[int'(ST_FROM_RANGE)],
                 ledger.status_seen[int'(ST_EXHAUSTED)], ledger.status_seen[int'(ST_FREED)],
                 ledger.status_seen[int'(ST_NOT_ALLOC)], ledger.status_seen[int'(ST_DUP_FULL)]);
        if (ledger.mismatches == 0)
            $display("stack_frame_allocator verification clean");
        else
            $display("stack_frame_allocator verification failed");
        $finish;
    end

endmodule
